FILE: rtl/core/tqbp_pkg.sv
// Shared types and constants for the ternary quantizer and bit-plane packer.
package tqbp_pkg;

  localparam int WORD_BITS   = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int THRESH_BITS = 15;

  // Input word: one channel sample of the current pixel
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_channel;
  } in_word_t;

  // Result word: packed bit planes of one channel group
  typedef struct packed {
    logic [WORD_BITS-1:0] negative_plane;
    logic [WORD_BITS-1:0] nonzero_plane;
    logic                 pixel_end;
  } out_word_t;

  // Ternary code of one sample
  typedef struct packed {
    logic neg;
    logic nz;
  } tern_t;

  // Control broadcast to every slot cell
  typedef struct packed {
    logic  accept;
    logic  emit;
    tern_t code;
  } cell_ctl_t;

endpackage

FILE: rtl/core/tqbp_quant.sv
// Ternary quantizer: compares one sample against +threshold and -threshold.
module tqbp_quant (
  input  logic signed [tqbp_pkg::SAMPLE_BITS-1:0] sample,
  input  logic        [tqbp_pkg::THRESH_BITS-1:0] threshold,
  output tqbp_pkg::tern_t                         code
);
  import tqbp_pkg::*;

  localparam int CMP_BITS = ((SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS) + 2;

  logic signed [CMP_BITS-1:0] s_ext;
  logic signed [CMP_BITS-1:0] t_pos;
  logic signed [CMP_BITS-1:0] t_neg;

  // Widen both operands so the negated threshold always fits
  assign s_ext = CMP_BITS'(sample);
  assign t_pos = $signed({{(CMP_BITS-THRESH_BITS){1'b0}}, threshold});
  assign t_neg = -t_pos;

  // Map to +1, -1 or 0
  always_comb begin
    code.neg = (s_ext < t_neg);
    code.nz  = (s_ext > t_pos) || (s_ext < t_neg);
  end

endmodule

FILE: rtl/core/tqbp_cell.sv
// One channel slot: holds its two plane bits and the fill token it passes on.
module tqbp_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                home,
  input  logic                tok_in,
  input  tqbp_pkg::cell_ctl_t ctl,
  output logic                tok_out,
  output logic                neg_bit,
  output logic                nz_bit
);
  import tqbp_pkg::*;

  logic tok_r,  tok_nxt;
  logic neg_r,  neg_nxt;
  logic nz_r,   nz_nxt;
  logic hit;

  // Capture the incoming code when this slot holds the token
  assign hit     = ctl.accept && tok_r;
  assign neg_bit = neg_r || (hit && ctl.code.neg);
  assign nz_bit  = nz_r  || (hit && ctl.code.nz);
  assign tok_out = tok_r;

  // Advance the token, clear on emit
  always_comb begin
    tok_nxt = tok_r;
    neg_nxt = neg_r;
    nz_nxt  = nz_r;
    if (ctl.accept && ctl.emit) begin
      tok_nxt = home;
      neg_nxt = 1'b0;
      nz_nxt  = 1'b0;
    end else if (ctl.accept) begin
      tok_nxt = tok_in;
      neg_nxt = neg_bit;
      nz_nxt  = nz_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= home;
      neg_r <= 1'b0;
      nz_r  <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
      neg_r <= neg_nxt;
      nz_r  <= nz_nxt;
    end
  end

endmodule

FILE: rtl/core/ternary_quantize_bit_pack.sv
// Top level: quantizer, row of slot cells with a fill token, output register.
// Throughput: one sample per cycle while in_stall is low; a full word and the next sample overlap.
// Output: the word pair is registered, valid in the cycle after the sample that closes it.
// The fill position is a one-hot token handed from cell to cell, 64 cells.
// Reset: token at slot 0, planes clear, threshold 0, output register empty.
module ternary_quantize_bit_pack (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  tqbp_pkg::in_word_t                  in_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output tqbp_pkg::out_word_t                 out_word,
  input  logic                                cfg_wr_en,
  input  logic [tqbp_pkg::THRESH_BITS-1:0]    cfg_wr_data
);
  import tqbp_pkg::*;

  logic [THRESH_BITS-1:0] thresh_r, thresh_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_word_t              out_word_r, out_word_nxt;

  tern_t                  code;
  cell_ctl_t              ctl;
  logic                   in_acc;
  logic [WORD_BITS-1:0]   tok_vec;
  logic [WORD_BITS-1:0]   neg_vec;
  logic [WORD_BITS-1:0]   nz_vec;

  // Hold input while a finished word is stalled
  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  tqbp_quant u_quant (
    .sample    (in_word.sample),
    .threshold (thresh_r),
    .code      (code)
  );

  // Broadcast control to the cell row
  always_comb begin
    ctl.accept = in_acc;
    ctl.emit   = in_word.last_channel || tok_vec[WORD_BITS-1];
    ctl.code   = code;
  end

  // Row of slot cells, token moves toward higher slots
  for (genvar i = 0; i < WORD_BITS; i++) begin : g_cell
    logic tok_prev;
    if (i == 0) begin : g_head
      assign tok_prev = 1'b0;
    end else begin : g_body
      assign tok_prev = tok_vec[i-1];
    end
    tqbp_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .home    ((i == 0) ? 1'b1 : 1'b0),
      .tok_in  (tok_prev),
      .ctl     (ctl),
      .tok_out (tok_vec[i]),
      .neg_bit (neg_vec[i]),
      .nz_bit  (nz_vec[i])
    );
  end

  // Load the threshold on a config write; load the output register on emit, drop it once taken
  always_comb begin
    thresh_nxt    = cfg_wr_en ? cfg_wr_data : thresh_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    if (in_acc && ctl.emit) begin
      out_valid_nxt               = 1'b1;
      out_word_nxt.negative_plane = neg_vec;
      out_word_nxt.nonzero_plane  = nz_vec;
      out_word_nxt.pixel_end      = in_word.last_channel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      thresh_r    <= thresh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef NO_ASSERTIONS
  a_tok_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(tok_vec))
    else $error("fill token not one-hot");

  a_full_emits: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && tok_vec[WORD_BITS-1] |=> out_valid_r)
    else $error("full word did not produce an output");

  a_tok_home: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && ctl.emit |=> tok_vec[0])
    else $error("token did not return to slot 0 after emit");

  a_pixel_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && ctl.emit |=> out_word_r.pixel_end == $past(in_word.last_channel))
    else $error("pixel_end does not match closing sample");
`endif

endmodule

FILE: test/tb.sv
// Self-checking testbench for the ternary quantizer and bit-plane packer.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tqbp_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  in_word_t               in_word = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_word_t              out_word;
  logic                   cfg_wr_en = 1'b0;
  logic [THRESH_BITS-1:0] cfg_wr_data = '0;

  ternary_quantize_bit_pack DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Samples waiting to be sent and plane pairs waiting to come back
  in_word_t  sample_queue[$];
  out_word_t plane_queue[$];

  // Shadow state of the packer
  int                   quant_threshold = 0;
  logic [WORD_BITS-1:0] neg_acc = '0;
  logic [WORD_BITS-1:0] nz_acc = '0;
  int                   fill_slot = 0;

  // Idle controls, set per phase by the sequencer
  int  tx_idle_pct = 0;
  int  rx_idle_pct = 0;
  bit  pressure_on = 1'b0;
  int  fail_count = 0;

  int  tx_gap = 0;
  int  rx_gap = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  // Quantize one accepted sample into the shadow planes; queue a pair when a word closes
  function automatic void pack_sample(in_word_t w);
    int        s;
    out_word_t r;
    s = int'(w.sample);
    if (s > quant_threshold) begin
      nz_acc[fill_slot] = 1'b1;
    end else if (s < -quant_threshold) begin
      neg_acc[fill_slot] = 1'b1;
      nz_acc[fill_slot] = 1'b1;
    end
    if (w.last_channel || fill_slot == WORD_BITS - 1) begin
      r.negative_plane = neg_acc;
      r.nonzero_plane  = nz_acc;
      r.pixel_end      = w.last_channel;
      plane_queue.push_back(r);
      neg_acc   = '0;
      nz_acc    = '0;
      fill_slot = 0;
    end else begin
      fill_slot++;
    end
  endfunction

  // Mostly short idle stretches, now and then a long one
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic void report_field(string field, logic [WORD_BITS-1:0] exp_v,
                                       logic [WORD_BITS-1:0] act_v);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch on %s: expected %h, got %h", field, exp_v, act_v);
  endfunction

  // Drive samples from the queue; track config writes and predict on every accepted word
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap   <= 0;
    end else begin
      if (cfg_wr_en)
        quant_threshold = int'(cfg_wr_data);
      if (in_valid && !in_stall)
        pack_sample(in_word);
      if (!in_valid || !in_stall) begin
        if (tx_gap > 0) begin
          in_valid <= 1'b0;
          tx_gap   <= tx_gap - 1;
        end else if (sample_queue.size() > 0) begin
          in_word  <= sample_queue.pop_front();
          in_valid <= 1'b1;
          tx_gap   <= ($urandom_range(0, 99) < tx_idle_pct) ? idle_length() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started once during the pressure phase
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (pressure_on && !hold_done) begin
      hold_left <= 300;
      hold_done <= 1'b1;
    end
  end

  // Check each accepted plane pair and drive the receiver stall
  always @(posedge clk) begin
    out_word_t exp_w;
    logic      stall_next;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_gap    <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (plane_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected word: neg %h nz %h end %b", out_word.negative_plane,
                     out_word.nonzero_plane, out_word.pixel_end);
        end else begin
          exp_w = plane_queue.pop_front();
          if (out_word.negative_plane !== exp_w.negative_plane)
            report_field("negative_plane", exp_w.negative_plane, out_word.negative_plane);
          if (out_word.nonzero_plane !== exp_w.nonzero_plane)
            report_field("nonzero_plane", exp_w.nonzero_plane, out_word.nonzero_plane);
          if (out_word.pixel_end !== exp_w.pixel_end)
            report_field("pixel_end", WORD_BITS'(exp_w.pixel_end),
                         WORD_BITS'(out_word.pixel_end));
        end
      end
      stall_next = 1'b0;
      if (rx_gap > 0) begin
        rx_gap     <= rx_gap - 1;
        stall_next = 1'b1;
      end else if ($urandom_range(0, 99) < rx_idle_pct) begin
        rx_gap     <= idle_length() - 1;
        stall_next = 1'b1;
      end
      out_stall <= stall_next || (hold_left != 0);
    end
  end

  function automatic void queue_sample(int s, bit last);
    in_word_t w;
    w.sample       = s[SAMPLE_BITS-1:0];
    w.last_channel = last;
    sample_queue.push_back(w);
  endfunction

  // Bias samples toward the threshold edges and the range extremes
  function automatic int pick_sample(int t);
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? 32767 : -32768;
      1:       return t;
      2:       return -t;
      3:       return t + 1;
      4:       return -t - 1;
      5:       return 0;
      default: return int'($signed(16'($urandom_range(0, 65535))));
    endcase
  endfunction

  // Queue whole pixels of random length; the phase may cut the last one short but still closes it
  function automatic void queue_pixels(int count, int t, int max_len);
    int len;
    int k;
    while (count > 0) begin
      case ($urandom_range(0, 9))
        0:       len = 1;
        1:       len = WORD_BITS;
        2:       len = 2 * WORD_BITS;
        3:       len = $urandom_range(0, 1) ? WORD_BITS - 1 : WORD_BITS + 1;
        4:       len = $urandom_range(WORD_BITS + 2, 3 * WORD_BITS);
        default: len = $urandom_range(2, 40);
      endcase
      if (len > max_len) len = $urandom_range(1, max_len);
      for (k = 0; k < len && count > 0; k++) begin
        queue_sample(pick_sample(t), k == len - 1 || count == 1);
        count--;
      end
    end
  endfunction

  // Wait until every sample is sent and every plane pair is back, then let the pipeline settle
  task automatic wait_idle();
    do @(negedge clk);
    while (sample_queue.size() != 0 || in_valid || plane_queue.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_threshold(int v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v[THRESH_BITS-1:0];
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(negedge clk);
  endtask

  // Run one random phase under a threshold and idle profile
  task automatic random_phase(int t, int count, int tx_pct, int rx_pct, int max_len);
    set_threshold(t);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    queue_pixels(count, t, max_len);
    wait_idle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset threshold of zero: only an exact zero stays zero
    queue_sample(0, 0);
    queue_sample(1, 0);
    queue_sample(-1, 0);
    queue_sample(32767, 0);
    queue_sample(-32768, 1);
    wait_idle();

    // Threshold edges at 1.0 in Q8.8
    set_threshold(256);
    queue_sample(256, 0);
    queue_sample(257, 0);
    queue_sample(-256, 0);
    queue_sample(-257, 0);
    queue_sample(255, 0);
    queue_sample(-255, 0);
    queue_sample(32767, 0);
    queue_sample(-32768, 0);
    queue_sample(0, 1);
    queue_sample(-300, 1);
    wait_idle();

    // Largest threshold: only the most negative sample passes
    set_threshold(32767);
    queue_sample(32767, 0);
    queue_sample(-32767, 0);
    queue_sample(-32768, 0);
    queue_sample(12345, 1);
    wait_idle();

    random_phase(0, 220, 0, 0, 3 * WORD_BITS);
    random_phase(32767, 220, 30, 30, 3 * WORD_BITS);
    random_phase(1, 220, 10, 40, 3 * WORD_BITS);
    random_phase(256, 220, 40, 10, 3 * WORD_BITS);

    // Receiver holds off while the sender streams short pixels without gaps
    set_threshold($urandom_range(0, 512));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    pressure_on = 1'b1;
    queue_pixels(200, quant_threshold, 8);
    wait_idle();
    pressure_on = 1'b0;

    random_phase($urandom_range(0, 32767), 220, 20, 20, 3 * WORD_BITS);
    random_phase($urandom_range(0, 1024), 220, 0, 50, 3 * WORD_BITS);
    random_phase($urandom_range(0, 32767), 220, 50, 0, 3 * WORD_BITS);

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
